[src/ready_queue_policy_select_unit_macros.svh]
// Assertion macros shared by the ready queue policy select unit.
`ifndef READY_QUEUE_POLICY_SELECT_UNIT_MACROS_SVH
`define READY_QUEUE_POLICY_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQPS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rqps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RQPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rqps assertion failed");

`endif

[src/rqps_pkg.sv]
// Package with the types and constants of the ready queue policy select unit.
package rqps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_W = 16;
    localparam int OCC_W = 5;

    // Operation codes of an input word.
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] ST_ENQ  = 2'd0;
    localparam logic [1:0] ST_DEQ  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Dequeue policy codes.
    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_PRIO  = 2'd1;
    localparam logic [1:0] POL_TOTAL = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic [KEY_W-1:0] PRIO_TOP   = 16'd10;
    localparam logic [KEY_W-1:0] TIME_LIMIT = 16'd9999;

    typedef struct packed {
        logic        op;
        logic [7:0]  task_id;
        logic [3:0]  priority_req;
        logic [15:0] next_burst;
        logic [15:0] total_remaining;
    } in_word_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_task_id;
        logic [OCC_W-1:0] occupancy;
    } out_word_t;

    // One stored queue entry.
    typedef struct packed {
        logic [7:0]  task_id;
        logic [3:0]  prio;
        logic [15:0] next_burst;
        logic [15:0] total;
    } entry_t;

    // Control from the sequencer to the selection unit.
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [1:0] policy;
    } pick_ctl_t;

endpackage

[src/ready_queue_policy_select_unit.sv]
// Top level of the ready queue with a selectable dequeue policy.
//
//  Channel   Direction  Handshake          Word
//  s_        in         s_valid/s_ready    in_word_t: op, task id, priority, bursts
//  m_        out        m_valid/m_ready    out_word_t: status, task id, occupancy
//  cfg_      in         cfg_we             policy register, written without wait
//
// An enqueue, a dropped enqueue or a dequeue from an empty queue goes from acceptance to the
// result handoff state and then to the output register, at which point the unit is ready again.
// A dequeue reads the entry RAM once per entry to select, then once per entry behind the
// selected one to close the gap, and skips the close-up pass when no entry qualifies; the
// reads go one at a time through the single read port of the entry RAM.
// Reset is synchronous and active low and empties the queue at once; entry contents are
// never cleared. The unit takes no new word while it works on one or while a finished
// result waits behind an unread output word.
module ready_queue_policy_select_unit
    import rqps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_wdata
);

`include "ready_queue_policy_select_unit_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // The sequencer: idle, selection walk, close-up pass, result handoff.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    out_word_t       res_reg, res_next;
    logic            m_valid_reg, m_valid_next;
    out_word_t       m_data_reg, m_data_next;
    logic [1:0]      policy_reg;

    logic            accept;
    logic            walk_done;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    entry_t          ram_wdata;
    entry_t          ram_rdata;

    pick_ctl_t       pick_ctl;
    logic            pick_found;
    logic [AW-1:0]   pick_sel;
    logic [7:0]      pick_task;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Every read issued has come back and been consumed.
    assign walk_done = (ptr_reg == count_reg) && !rd_vld_reg;

    rqps_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign pick_ctl.clear  = accept;
    assign pick_ctl.step   = rd_vld_reg && (state_reg == S_SCAN);
    assign pick_ctl.policy = policy_reg;

    rqps_pick #(
        .DEPTH (QUEUE_DEPTH)
    ) u_pick (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (pick_ctl),
        .idx      (rd_idx_reg),
        .entry    (ram_rdata),
        .found    (pick_found),
        .sel      (pick_sel),
        .sel_task (pick_task)
    );

    // Entry RAM write port: an enqueue appends at the tail, the close-up pass moves each
    // entry behind the removed one down by one place as its read data returns.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata.task_id    = s_data.task_id;
        ram_wdata.prio       = s_data.priority_req;
        ram_wdata.next_burst = s_data.next_burst;
        ram_wdata.total      = s_data.total_remaining;
        if (accept && (s_data.op == OP_ENQ) && (count_reg < CW'(QUEUE_DEPTH))) begin
            ram_we = 1'b1;
        end else if ((state_reg == S_SHIFT) && rd_vld_reg) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx_reg - AW'(1);
            ram_wdata = ram_rdata;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next.out_task_id = '0;
                    if (s_data.op == OP_ENQ) begin
                        if (count_reg < CW'(QUEUE_DEPTH)) begin
                            count_next         = count_reg + CW'(1);
                            res_next.status    = ST_ENQ;
                            res_next.occupancy = OCC_W'(count_reg + CW'(1));
                        end else begin
                            res_next.status    = ST_FULL;
                            res_next.occupancy = OCC_W'(count_reg);
                        end
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        res_next.status    = ST_NONE;
                        res_next.occupancy = OCC_W'(count_reg);
                        state_next         = S_DONE;
                    end else begin
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (ptr_reg < count_reg) begin
                    ptr_next    = ptr_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                end else if (walk_done) begin
                    if (pick_found) begin
                        ptr_next   = CW'(pick_sel) + CW'(1);
                        state_next = S_SHIFT;
                    end else begin
                        res_next.status      = ST_NONE;
                        res_next.out_task_id = '0;
                        res_next.occupancy   = OCC_W'(count_reg);
                        state_next           = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (ptr_reg < count_reg) begin
                    ptr_next    = ptr_reg + CW'(1);
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                end else if (walk_done) begin
                    count_next           = count_reg - CW'(1);
                    res_next.status      = ST_DEQ;
                    res_next.out_task_id = pick_task;
                    res_next.occupancy   = OCC_W'(count_reg - CW'(1));
                    state_next           = S_DONE;
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            policy_reg  <= POL_FIFO;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                policy_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The fill count never passes the queue depth.
    `RQPS_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(QUEUE_DEPTH))

    // An enqueue into a queue with room grows the count by exactly one.
    `RQPS_ASSERT_NEXT(a_enq_grows, aclk, aresetn,
        accept && (s_data.op == OP_ENQ) && (count_reg < CW'(QUEUE_DEPTH)),
        count_reg == $past(count_reg) + CW'(1))

    // A selection made by the walk always points inside the filled part of the queue.
    `RQPS_ASSERT_SAME(a_sel_in_range, aclk, aresetn,
        (state_reg == S_SCAN) && walk_done && pick_found,
        CW'(pick_sel) < count_reg)

endmodule

[src/rqps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/rqps_pick.sv]
// Shared compare unit that walks the entries one a cycle and keeps the selected one.
module rqps_pick
    import rqps_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  pick_ctl_t       ctl,
    input  logic [AW-1:0]   idx,
    input  entry_t          entry,
    output logic            found,
    output logic [AW-1:0]   sel,
    output logic [7:0]      sel_task
);

    logic             found_reg;
    logic             taken_reg;
    logic [KEY_W-1:0] best_reg;
    logic [AW-1:0]    sel_reg;
    logic [7:0]       task_reg;

    logic [KEY_W-1:0] key;
    logic             key_lt;
    logic             key_gt;
    logic             upd;
    logic             take;

    always_comb begin
        case (ctl.policy)
            POL_PRIO:  key = KEY_W'(entry.prio);
            POL_TOTAL: key = entry.total;
            POL_NEXT:  key = entry.next_burst;
            default:   key = '0;
        endcase
    end

    assign key_lt = key < best_reg;
    assign key_gt = best_reg < key;

    always_comb begin
        upd  = 1'b0;
        take = 1'b0;
        case (ctl.policy)
            POL_FIFO: begin
                upd = !found_reg;
            end
            POL_PRIO: begin
                // A priority of exactly ten that becomes the running maximum ends the search.
                upd  = !taken_reg && (!found_reg || key_gt);
                take = upd && (key == PRIO_TOP);
            end
            POL_TOTAL, POL_NEXT: begin
                upd = (key <= TIME_LIMIT) && (!found_reg || key_lt);
            end
            default: begin
                upd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            taken_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
            taken_reg <= 1'b0;
        end else if (ctl.step && upd) begin
            found_reg <= 1'b1;
            taken_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            best_reg <= '0;
        end else if (ctl.step && upd) begin
            best_reg <= key;
            sel_reg  <= idx;
            task_reg <= entry.task_id;
        end
    end

    assign found    = found_reg;
    assign sel      = sel_reg;
    assign sel_task = task_reg;

endmodule
